// ===== design/bfsa_pkg.sv =====
`default_nettype none
package bfsa_pkg;

  // Index width that covers the largest supported table.
  localparam int unsigned IDX_W = 10;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_STATS = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EDIT,
    S_SHIFT,
    S_STAT,
    S_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_ROTATE,
    OP_WRITE,
    OP_INSERT,
    OP_DELETE
  } cell_op_e;

  typedef struct packed {
    logic [15:0] off;
    logic [15:0] size;
    logic        used;
  } seg_t;

  typedef struct packed {
    cell_op_e         op;
    logic [IDX_W-1:0] idx;
    seg_t             w0;
    seg_t             w1;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/bfsa_cell.sv =====
`default_nettype none
module bfsa_cell import bfsa_pkg::*; #(
  parameter int unsigned IDX     = 0,
  parameter seg_t        RST_SEG = '0
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  seg_t       prev_i,
  input  seg_t       next_i,
  output seg_t       seg_o
);

  localparam logic [IDX_W:0] MyIdx = (IDX_W + 1)'(IDX);

  seg_t           seg_q, seg_d;
  logic [IDX_W:0] idx_w, idx_p1;

  assign idx_w  = {1'b0, ctrl_i.idx};
  assign idx_p1 = idx_w + 1'b1;

  always_comb begin
    seg_d = seg_q;
    unique case (ctrl_i.op)
      OP_HOLD: ;
      OP_ROTATE: seg_d = next_i;
      OP_WRITE: begin
        if (MyIdx == idx_w) seg_d = ctrl_i.w0;
      end
      OP_INSERT: begin
        // Entries above the split move up by one to open a slot.
        if (MyIdx == idx_w) seg_d = ctrl_i.w0;
        else if (MyIdx == idx_p1) seg_d = ctrl_i.w1;
        else if (MyIdx > idx_p1) seg_d = prev_i;
      end
      OP_DELETE: begin
        if (MyIdx > idx_w) seg_d = next_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seg_q <= RST_SEG;
    else seg_q <= seg_d;
  end

  assign seg_o = seg_q;

endmodule
`default_nettype wire

// ===== design/best_fit_segment_allocator.sv =====
`default_nettype none
// Channel  Dir  Handshake                 Payload
// s_axis   in   tvalid_i / tready_o       tuser: kind; tdata: request_size, block_address
// m_axis   out  tvalid_o / tready_i       tdata: status .. free_segments
//
// An allocate or free word is served by the segment ring, which rotates once past
// the head cell to search and once more to gather statistics; a free word that
// merges neighbours also shifts out each segment removed. A statistics word
// rotates the ring only once, to gather statistics.
// Reset leaves one free segment and no result pending. A stalled result holds in
// the output register; the next word is taken meanwhile but waits before output.
// ALIGN_BYTES must be a power of two.
module best_fit_segment_allocator import bfsa_pkg::*; #(
  parameter int unsigned POOL_BYTES        = 65536,
  parameter int unsigned NODE_HEADER_BYTES = 12,
  parameter int unsigned MANAGER_BYTES     = 12,
  parameter int unsigned MAX_SEGMENTS      = 64,
  parameter int unsigned ALIGN_BYTES       = 4
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] request_size, [31:16] block_address
  input  wire  [31:0] s_axis_tdata_i,
  // [1:0] kind
  input  wire  [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  // [1:0] status, [17:2] data_address, [33:18] largest_free, [50:34] used_bytes,
  // [57:51] used_segments, [64:58] free_segments, [71:65] zero
  output logic [71:0] m_axis_tdata_o
);

  localparam int unsigned N  = MAX_SEGMENTS;
  localparam int unsigned IW = $clog2(N);
  localparam int unsigned CW = $clog2(N + 1);
  localparam logic [16:0] HDR   = 17'(NODE_HEADER_BYTES);
  localparam logic [16:0] AMASK = 17'(ALIGN_BYTES - 1);
  localparam seg_t RST0 = '{off: 16'(MANAGER_BYTES),
      size: 16'(POOL_BYTES - MANAGER_BYTES - NODE_HEADER_BYTES), used: 1'b0};

  seg_t       segs [N];
  cell_ctrl_t ctrl;

  for (genvar g = 0; g < N; g++) begin : g_cell
    bfsa_cell #(.IDX(g), .RST_SEG(g == 0 ? RST0 : seg_t'(0))) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .prev_i (segs[(g + N - 1) % N]),
      .next_i (segs[(g + 1) % N]),
      .seg_o  (segs[g])
    );
  end

  state_e        state_q, state_d;
  logic [IW-1:0] step_q, step_d;
  logic [CW-1:0] count_q, count_d;
  logic [1:0]    kind_q, kind_d;
  logic [16:0]   want_q, want_d;
  logic [15:0]   baddr_q, baddr_d;
  logic          found_q, found_d;
  logic [IW-1:0] bidx_q, bidx_d;
  seg_t          bseg_q, bseg_d;
  logic          inrun_q, inrun_d, ext_q, ext_d;
  logic [IW-1:0] rs_idx_q, rs_idx_d, lo_q, lo_d, hi_q, hi_d, gone_q, gone_d;
  logic [15:0]   rs_off_q, rs_off_d, lo_off_q, lo_off_d;
  logic [16:0]   hi_end_q, hi_end_d;
  logic [1:0]    status_q, status_d;
  logic [15:0]   daddr_q, daddr_d;
  logic [15:0]   large_q, large_d;
  logic [16:0]   used_q, used_d;
  logic [CW-1:0] nused_q, nused_d, nfree_q, nfree_d;
  logic          out_valid_q, out_valid_d;
  logic [71:0]   out_data_q, out_data_d;

  seg_t        head;
  logic        live, last, split;
  logic [16:0] diff;

  assign head  = segs[0];
  assign live  = (CW + 1)'(step_q) < {1'b0, count_q};
  assign last  = step_q == IW'(N - 1);
  assign diff  = {1'b0, bseg_q.size} - want_q;
  assign split = (diff > HDR) && (count_q < CW'(N));

  always_comb begin
    state_d = state_q; step_d = step_q; count_d = count_q; kind_d = kind_q;
    want_d = want_q; baddr_d = baddr_q; found_d = found_q; bidx_d = bidx_q;
    bseg_d = bseg_q; inrun_d = inrun_q; ext_d = ext_q; rs_idx_d = rs_idx_q;
    rs_off_d = rs_off_q; lo_d = lo_q; hi_d = hi_q; lo_off_d = lo_off_q;
    hi_end_d = hi_end_q; gone_d = gone_q; status_d = status_q; daddr_d = daddr_q;
    large_d = large_q; used_d = used_q; nused_d = nused_q; nfree_d = nfree_q;
    out_valid_d = out_valid_q; out_data_d = out_data_q;
    ctrl = '{op: OP_HOLD, idx: '0, w0: '0, w1: '0};
    s_axis_tready_o = 1'b0;

    if (m_axis_tready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          kind_d   = s_axis_tuser_i;
          want_d   = ({1'b0, s_axis_tdata_i[15:0]} + AMASK) & ~AMASK;
          baddr_d  = s_axis_tdata_i[31:16];
          found_d  = 1'b0;
          inrun_d  = 1'b0;
          ext_d    = 1'b0;
          status_d = ST_OK;
          daddr_d  = '0;
          step_d   = '0;
          state_d  = (s_axis_tuser_i == KIND_ALLOC || s_axis_tuser_i == KIND_FREE)
                     ? S_SCAN : S_STAT;
        end
      end
      S_SCAN: begin
        ctrl.op = OP_ROTATE;
        if (live) begin
          if (kind_q == KIND_ALLOC) begin
            // Ties go to the later entry, the one at the higher address.
            if (!head.used && {1'b0, head.size} >= want_q &&
                (!found_q || head.size <= bseg_q.size)) begin
              found_d = 1'b1; bidx_d = step_q; bseg_d = head;
            end
          end else if (!found_q) begin
            if (head.used && ({1'b0, head.off} + HDR) == {1'b0, baddr_q}) begin
              found_d  = 1'b1; bidx_d = step_q; bseg_d = head;
              lo_d     = inrun_q ? rs_idx_q : step_q;
              lo_off_d = inrun_q ? rs_off_q : head.off;
              hi_d     = step_q;
              hi_end_d = {1'b0, head.off} + {1'b0, head.size};
              ext_d    = 1'b1;
            end else if (!head.used) begin
              if (!inrun_q) begin
                inrun_d = 1'b1; rs_idx_d = step_q; rs_off_d = head.off;
              end
            end else begin
              inrun_d = 1'b0;
            end
          end else if (ext_q) begin
            if (!head.used) begin
              hi_d = step_q;
              hi_end_d = {1'b0, head.off} + {1'b0, head.size};
            end else begin
              ext_d = 1'b0;
            end
          end
        end
        step_d = last ? '0 : step_q + 1'b1;
        if (last) begin
          if (found_d) state_d = S_EDIT;
          else begin
            status_d = (kind_q == KIND_ALLOC) ? ST_NO_SPACE : ST_BAD_ADDR;
            state_d  = S_STAT;
          end
        end
      end
      S_EDIT: begin
        state_d = S_STAT;
        if (kind_q == KIND_ALLOC) begin
          ctrl.idx = IDX_W'(bidx_q);
          daddr_d  = 16'({1'b0, bseg_q.off} + HDR);
          if (split) begin
            ctrl.op = OP_INSERT;
            ctrl.w0 = '{off: bseg_q.off, size: want_q[15:0], used: 1'b1};
            ctrl.w1 = '{off: 16'({1'b0, bseg_q.off} + HDR + want_q),
                        size: 16'(diff - HDR), used: 1'b0};
            count_d = count_q + 1'b1;
          end else begin
            ctrl.op = OP_WRITE;
            ctrl.w0 = '{off: bseg_q.off, size: bseg_q.size, used: 1'b1};
          end
        end else begin
          ctrl.op = OP_WRITE;
          if (hi_q == lo_q) begin
            ctrl.idx = IDX_W'(bidx_q);
            ctrl.w0  = '{off: bseg_q.off, size: bseg_q.size, used: 1'b0};
          end else begin
            ctrl.idx = IDX_W'(lo_q);
            ctrl.w0  = '{off: lo_off_q, size: 16'(hi_end_q - {1'b0, lo_off_q}),
                         used: 1'b0};
            gone_d   = hi_q - lo_q;
            count_d  = count_q - CW'(hi_q - lo_q);
            state_d  = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // Each cycle closes the gap above the merged segment by one entry.
        ctrl.op  = OP_DELETE;
        ctrl.idx = IDX_W'(lo_q);
        gone_d   = gone_q - 1'b1;
        if (gone_q == IW'(1)) state_d = S_STAT;
      end
      S_STAT: begin
        ctrl.op = OP_ROTATE;
        large_d = (step_q == '0) ? '0 : large_q;
        used_d  = (step_q == '0) ? 17'(MANAGER_BYTES) : used_q;
        nused_d = (step_q == '0) ? '0 : nused_q;
        nfree_d = (step_q == '0) ? '0 : nfree_q;
        if (live) begin
          if (head.used) begin
            used_d  = used_d + {1'b0, head.size} + HDR;
            nused_d = nused_d + 1'b1;
          end else begin
            if (head.size > large_d) large_d = head.size;
            nfree_d = nfree_d + 1'b1;
          end
        end
        step_d = last ? '0 : step_q + 1'b1;
        if (last) state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {7'd0, 7'(nfree_q), 7'(nused_q), used_q, large_q, daddr_q,
                         status_q};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      count_q     <= CW'(1);
      found_q     <= 1'b0;
      inrun_q     <= 1'b0;
      ext_q       <= 1'b0;
      gone_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      found_q     <= found_d;
      inrun_q     <= inrun_d;
      ext_q       <= ext_d;
      gone_q      <= gone_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    want_q     <= want_d;
    baddr_q    <= baddr_d;
    bidx_q     <= bidx_d;
    bseg_q     <= bseg_d;
    rs_idx_q   <= rs_idx_d;
    rs_off_q   <= rs_off_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    lo_off_q   <= lo_off_d;
    hi_end_q   <= hi_end_d;
    status_q   <= status_d;
    daddr_q    <= daddr_d;
    large_q    <= large_d;
    used_q     <= used_d;
    nused_q    <= nused_d;
    nfree_q    <= nfree_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
`default_nettype wire

// ===== design/bfsa_checker.sv =====
`default_nettype none
module bfsa_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        m_axis_tvalid_o,
  input wire        m_axis_tready_i,
  input wire [71:0] m_axis_tdata_o
);

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[1:0] != 2'd3)
    else $error("undefined status code");

  a_addr_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[1:0] != 2'd0) |-> m_axis_tdata_o[17:2] == 16'd0)
    else $error("failed word carries an address");

  a_some_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[57:51] != 7'd0 || m_axis_tdata_o[64:58] != 7'd0))
    else $error("word reports an empty table");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled word changed");

endmodule

bind best_fit_segment_allocator bfsa_checker u_bfsa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire
